@@ rtl/ila_pkg.sv @@
// shared types and constants for the indexed list block
// field widths, command and status codes, controller/datapath bundles
// no dependencies
package ila_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_UPDATE = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic wr_tail;
        logic wr_pos;
        logic wr_pos_inc;
        logic rd_tail;
        logic rd_pos;
        logic ins_start;
        logic del_start;
        logic shift_step;
        logic cap_dout;
        logic cnt_dec;
        logic rsp_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             ok;
        logic             append;
        logic             del_last;
        logic             last_move;
        logic             rsp_free;
    } dp_stat_t;

endpackage

@@ rtl/ila_if.sv @@
// valid/ready channel interfaces for the indexed list block
// request channel carries a command, response channel carries its result
// depends on ila_pkg
interface ila_req_if;
    import ila_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output cmd, output position, output data_in, input ready);
    modport sink   (input valid, input cmd, input position, input data_in, output ready);
endinterface

interface ila_rsp_if;
    import ila_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output data_out, output status, output count, input ready);
    modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

@@ rtl/ila_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ila_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/ila_dp.sv @@
// datapath of the indexed list: command latch, entry count, shift pointers,
// entry ram and response register
// depends on ila_pkg, ila_if, ila_ram
module ila_dp #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ila_pkg::ctrl_cmd_t          ctl,
    output ila_pkg::dp_stat_t           sts,
    input  logic [ila_pkg::CMD_W-1:0]   req_cmd,
    input  logic [ila_pkg::POS_W-1:0]   req_position,
    input  logic [ila_pkg::DATA_W-1:0]  req_data_in,
    ila_rsp_if.source                   rsp
);
    import ila_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CMD_W-1:0]     op_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [ELEM_BITS-1:0] val_reg;
    status_t              st_reg;
    logic [ELEM_BITS-1:0] dout_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]        mv_reg, mv_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]    rsp_data_reg;
    status_t              rsp_status_reg;
    logic [CNT_W-1:0]     rsp_count_reg;

    status_t              st_new;
    logic [CMPW-1:0]      req_pos_ext, pos_ext, cnt_ext;
    logic                 is_full;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        tail_addr, last_addr, pos_addr;
    logic                 more_reads;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ELEM_BITS-1:0] ram_wdata, ram_rdata;

    assign req_pos_ext = CMPW'(req_position);
    assign pos_ext     = CMPW'(pos_reg);
    assign cnt_ext     = CMPW'(cnt_reg);
    assign is_full     = (cnt_reg == CW'(DEPTH));
    assign cnt_m1      = cnt_reg - CW'(1);
    assign tail_addr   = cnt_reg[AW-1:0];
    assign last_addr   = cnt_m1[AW-1:0];
    assign pos_addr    = pos_ext[AW-1:0];
    assign more_reads  = (mv_reg > CW'(1));

    // status of the incoming command against the current count
    always_comb
    begin
        st_new = ST_OK;
        case (cmd_t'(req_cmd))
            CMD_PUSH:
            begin
                if (is_full)
                    st_new = ST_FULL;
            end
            CMD_POP:
            begin
                if (cnt_reg == '0)
                    st_new = ST_BAD;
            end
            CMD_INSERT:
            begin
                if (req_pos_ext > cnt_ext)
                    st_new = ST_BAD;
                else if (is_full)
                    st_new = ST_FULL;
            end
            CMD_DELETE, CMD_UPDATE, CMD_READ:
            begin
                if (req_pos_ext >= cnt_ext)
                    st_new = ST_BAD;
            end
            default:
            begin
                st_new = ST_BAD;
            end
        endcase
    end

    // ram port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_addr;
        ram_wdata = val_reg;
        if (ctl.wr_tail)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.wr_pos || ctl.wr_pos_inc)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr;
        end
        else if (ctl.shift_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_reg;
            ram_wdata = ram_rdata;
        end

        ram_re    = 1'b0;
        ram_raddr = last_addr;
        if (ctl.rd_tail || ctl.ins_start)
        begin
            ram_re = 1'b1;
        end
        else if (ctl.rd_pos)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_addr;
        end
        else if (ctl.del_start)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_addr + AW'(1);
        end
        else if (ctl.shift_step && more_reads)
        begin
            ram_re    = 1'b1;
            ram_raddr = rd_ptr_reg;
        end
    end

    // shift pointers: insert walks down, delete walks up
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mv_next     = mv_reg;
        if (ctl.ins_start)
        begin
            rd_ptr_next = last_addr - AW'(1);
            wr_ptr_next = tail_addr;
            mv_next     = CW'(cnt_ext - pos_ext);
        end
        else if (ctl.del_start)
        begin
            rd_ptr_next = pos_addr + AW'(2);
            wr_ptr_next = pos_addr;
            mv_next     = CW'(cnt_ext - pos_ext - CMPW'(1));
        end
        else if (ctl.shift_step)
        begin
            mv_next = mv_reg - CW'(1);
            if (op_reg == CMD_INSERT)
            begin
                wr_ptr_next = wr_ptr_reg - AW'(1);
                rd_ptr_next = rd_ptr_reg - AW'(1);
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + AW'(1);
                rd_ptr_next = rd_ptr_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.wr_tail || ctl.wr_pos_inc)
            cnt_next = cnt_reg + CW'(1);
        else if (ctl.cnt_dec)
            cnt_next = cnt_m1;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        mv_reg     <= mv_next;
        if (ctl.load)
        begin
            op_reg   <= req_cmd;
            pos_reg  <= req_position;
            val_reg  <= ELEM_BITS'(req_data_in);
            st_reg   <= st_new;
            dout_reg <= '0;
        end
        else if (ctl.cap_dout)
        begin
            dout_reg <= ram_rdata;
        end
        if (ctl.rsp_load)
        begin
            rsp_data_reg   <= DATA_W'(dout_reg);
            rsp_status_reg <= st_reg;
            rsp_count_reg  <= CNT_W'(cnt_reg);
        end
    end

    ila_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.op        = op_reg;
    assign sts.ok        = (st_reg == ST_OK);
    assign sts.append    = (pos_ext == cnt_ext);
    assign sts.del_last  = (CMPW'(pos_ext + CMPW'(1)) == cnt_ext);
    assign sts.last_move = (mv_reg == CW'(1));
    assign sts.rsp_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.data_out = rsp_data_reg;
    assign rsp.status   = rsp_status_reg;
    assign rsp.count    = rsp_count_reg;
endmodule

@@ rtl/ila_ctrl.sv @@
// controller of the indexed list: sequences one command through the datapath
// depends on ila_pkg
module ila_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output ila_pkg::ctrl_cmd_t ctl,
    input  ila_pkg::dp_stat_t  sts
);
    import ila_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RDATA = 6'b000100,
        S_SHIFT = 6'b001000,
        S_FILL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (sts.ok)
                begin
                    case (cmd_t'(sts.op))
                        CMD_PUSH:
                        begin
                            ctl.wr_tail = 1'b1;
                        end
                        CMD_POP:
                        begin
                            ctl.rd_tail = 1'b1;
                            ctl.cnt_dec = 1'b1;
                            state_next  = S_RDATA;
                        end
                        CMD_INSERT:
                        begin
                            if (sts.append)
                            begin
                                ctl.wr_pos_inc = 1'b1;
                            end
                            else
                            begin
                                ctl.ins_start = 1'b1;
                                state_next    = S_SHIFT;
                            end
                        end
                        CMD_DELETE, CMD_READ:
                        begin
                            ctl.rd_pos = 1'b1;
                            state_next = S_RDATA;
                        end
                        CMD_UPDATE:
                        begin
                            ctl.wr_pos = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                ctl.cap_dout = 1'b1;
                state_next   = S_DONE;
                if (sts.op == CMD_DELETE)
                begin
                    if (sts.del_last)
                    begin
                        ctl.cnt_dec = 1'b1;
                    end
                    else
                    begin
                        ctl.del_start = 1'b1;
                        state_next    = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (sts.last_move)
                begin
                    if (sts.op == CMD_INSERT)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        ctl.cnt_dec = 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                ctl.wr_pos_inc = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.rsp_free)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

@@ rtl/indexed_list_insert_delete.sv @@
// Ordered list of up to DEPTH entries of ELEM_BITS held in one ram with a
// registered read port. Each request (push, pop, insert, delete, update,
// read) returns one response with the removed or read entry, a status and
// the new count. Requests are handled one at a time; the response sits in
// an output register so the next request can be taken while it waits.
// Push, update, insert at the end and any rejected command finish without
// moving entries; delete and insert elsewhere move the entries behind the
// position one per cycle through the single ram write port.
// A response that has not been taken holds the next command in its final
// state (S_DONE) until the receiver takes it.
// Entries are not cleared at reset; only the count, the response valid flag
// and the controller state reset.
// depends on ila_pkg, ila_if, ila_ram, ila_dp, ila_ctrl
module indexed_list_insert_delete #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ila_req_if.sink   req,
    ila_rsp_if.source rsp
);
    import ila_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  sts;

    ila_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    ila_dp #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .req_cmd      (req.cmd),
        .req_position (req.position),
        .req_data_in  (req.data_in),
        .rsp          (rsp)
    );

    // one request in flight at a time
    a_single_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while a command is in flight");

    a_rsp_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rsp_load |-> sts.rsp_free)
        else $error("response loaded over an untaken response");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.wr_tail, ctl.wr_pos, ctl.wr_pos_inc, ctl.shift_step}))
        else $error("conflicting ram writes");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(ctl.rsp_load))
        else $error("response valid without a load");
endmodule
